// File: src/ipv4_header_receive_check_top_macros.svh
// assertion macros for the ipv4 header receive check block
// used by the top level only; define NO_ASSERTIONS to drop the checks
`ifndef IPV4_HEADER_RECEIVE_CHECK_TOP_MACROS_SVH
`define IPV4_HEADER_RECEIVE_CHECK_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define IHRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ihrc assertion failed");

// antecedent implies consequent in the next cycle
`define IHRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ihrc assertion failed");

`else

`define IHRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define IHRC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/ihrc_pkg.sv
// shared types, constants and helpers for the ipv4 header receive check
// used by every module of the block; depends on nothing
`default_nettype none

package ihrc_pkg;

  // header layout and checked values
  localparam logic [15:0] HDR_BYTES        = 16'd20;
  localparam logic [3:0]  EXPECTED_VERSION = 4'd4;
  localparam logic [3:0]  IHL_WORDS        = 4'd5;
  localparam logic [7:0]  PROTO_ICMP       = 8'd1;
  localparam logic [7:0]  VERSION_MASK     = 8'hf0;
  localparam logic [7:0]  IHL_MASK         = 8'h0f;
  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
  localparam logic [15:0] SUM_GOOD         = 16'hFFFF;

  // header byte positions
  localparam logic [4:0] POS_VERSION_IHL = 5'd0;
  localparam logic [4:0] POS_LENGTH_HI   = 5'd2;
  localparam logic [4:0] POS_LENGTH_LO   = 5'd3;
  localparam logic [4:0] POS_PROTOCOL    = 5'd9;
  localparam logic [4:0] POS_CKSUM_HI    = 5'd10;
  localparam logic [4:0] POS_CKSUM_LO    = 5'd11;
  localparam logic [4:0] POS_SRC_FIRST   = 5'd12;
  localparam logic [4:0] POS_SRC_LAST    = 5'd15;
  localparam logic [4:0] POS_DST_FIRST   = 5'd16;
  localparam logic [4:0] POS_DST_LAST    = 5'd19;

  // configuration register indexes and reset values
  localparam logic CFG_BUFFER_CAPACITY = 1'b0;
  localparam logic CFG_MAX_LENGTH      = 1'b1;
  localparam logic [15:0] BUFFER_CAPACITY_RESET = 16'd2048;
  localparam logic [15:0] MAX_LENGTH_RESET      = 16'd1500;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // result status codes, in check priority order
  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_BUFFER   = 3'd1,
    STATUS_SHORT    = 3'd2,
    STATUS_TOO_LONG = 3'd3,
    STATUS_VERSION  = 3'd4,
    STATUS_IHL      = 3'd5,
    STATUS_LENGTH   = 3'd6,
    STATUS_CHECKSUM = 3'd7
  } status_t;

  // everything captured from one packet, handed from front to back
  typedef struct packed {
    logic [15:0] byte_count;
    logic [15:0] sum;
    logic [15:0] rx_checksum;
    logic [7:0]  version_ihl;
    logic [15:0] total_length;
    logic [7:0]  protocol;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
  } pkt_rec_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// File: src/ihrc_front.sv
// front end: takes packet bytes, counts them, sums and captures the header
// depends on ihrc_pkg
`default_nettype none

module ihrc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic                   push,
  output ihrc_pkg::pkt_rec_t     rec
);

  logic [15:0] byte_count, byte_count_next;
  logic [15:0] sum, sum_next;
  logic [7:0]  high_hold, high_hold_next;
  logic [7:0]  version_ihl, version_ihl_next;
  logic [15:0] total_length, total_length_next;
  logic [7:0]  protocol, protocol_next;
  logic [15:0] rx_checksum, rx_checksum_next;
  logic [31:0] source_ip, source_ip_next;
  logic [31:0] dest_ip, dest_ip_next;
  logic [4:0]  pos;

  assign pos = byte_count[4:0];

  // per-byte capture and running sum
  always_comb begin
    byte_count_next   = byte_count;
    sum_next          = sum;
    high_hold_next    = high_hold;
    version_ihl_next  = version_ihl;
    total_length_next = total_length;
    protocol_next     = protocol;
    rx_checksum_next  = rx_checksum;
    source_ip_next    = source_ip;
    dest_ip_next      = dest_ip;
    if (accept) begin
      if (byte_count < ihrc_pkg::HDR_BYTES) begin
        case (pos) inside
          ihrc_pkg::POS_VERSION_IHL: version_ihl_next = data_byte;
          ihrc_pkg::POS_LENGTH_HI:   total_length_next = {data_byte, 8'd0};
          ihrc_pkg::POS_LENGTH_LO:   total_length_next = {total_length[15:8], data_byte};
          ihrc_pkg::POS_PROTOCOL:    protocol_next = data_byte;
          ihrc_pkg::POS_CKSUM_HI:    rx_checksum_next = {data_byte, 8'd0};
          ihrc_pkg::POS_CKSUM_LO:    rx_checksum_next = {rx_checksum[15:8], data_byte};
          [ihrc_pkg::POS_SRC_FIRST:ihrc_pkg::POS_SRC_LAST]:
            source_ip_next = {source_ip[23:0], data_byte};
          [ihrc_pkg::POS_DST_FIRST:ihrc_pkg::POS_DST_LAST]:
            dest_ip_next = {dest_ip[23:0], data_byte};
          default: ;
        endcase
        // even bytes wait for their partner, odd bytes close a word (the checksum word is not summed)
        if (!pos[0]) begin
          high_hold_next = data_byte;
        end else if (pos != ihrc_pkg::POS_CKSUM_LO) begin
          sum_next = ihrc_pkg::oc_add(sum, {high_hold, data_byte});
        end
      end
      // saturating byte counter
      if (byte_count != ihrc_pkg::COUNT_MAX) begin
        byte_count_next = byte_count + 16'd1;
      end
    end
  end

  // packet record goes out on the last byte
  assign push = accept && last_byte;
  always_comb begin
    rec.byte_count   = byte_count_next;
    rec.sum          = sum_next;
    rec.rx_checksum  = rx_checksum_next;
    rec.version_ihl  = version_ihl_next;
    rec.total_length = total_length_next;
    rec.protocol     = protocol_next;
    rec.source_ip    = source_ip_next;
    rec.dest_ip      = dest_ip_next;
  end

  // per-packet state, cleared after each record
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count   <= '0;
      sum          <= '0;
      high_hold    <= '0;
      version_ihl  <= '0;
      total_length <= '0;
      protocol     <= '0;
      rx_checksum  <= '0;
      source_ip    <= '0;
      dest_ip      <= '0;
    end else begin
      byte_count   <= byte_count_next;
      sum          <= sum_next;
      high_hold    <= high_hold_next;
      version_ihl  <= version_ihl_next;
      total_length <= total_length_next;
      protocol     <= protocol_next;
      rx_checksum  <= rx_checksum_next;
      source_ip    <= source_ip_next;
      dest_ip      <= dest_ip_next;
    end
  end

endmodule

`default_nettype wire

// File: src/ihrc_queue.sv
// short record queue between front and back, push and pop may happen in the same cycle
// depends on ihrc_pkg
`default_nettype none

module ihrc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ihrc_pkg::pkt_rec_t push_rec,
  output logic                   full,
  output logic                   not_empty,
  input  wire logic              pop,
  output ihrc_pkg::pkt_rec_t     head
);

  ihrc_pkg::pkt_rec_t entries [ihrc_pkg::QUEUE_DEPTH];
  logic [ihrc_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [ihrc_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [ihrc_pkg::QUEUE_CNT_W-1:0] count;

  assign full      = (count == ihrc_pkg::QUEUE_CNT_W'(ihrc_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // record storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ihrc_pkg::QUEUE_PTR_W'(ihrc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ihrc_pkg::QUEUE_PTR_W'(ihrc_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/ihrc_back.sv
// back end: configuration registers, header checks and the result register
// depends on ihrc_pkg
`default_nettype none

module ihrc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              rec_valid,
  input  wire ihrc_pkg::pkt_rec_t rec,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [7:0]             protocol_number,
  output logic [31:0]            reply_source,
  output logic [31:0]            reply_destination,
  output logic [15:0]            reply_checksum,
  output logic                   echo_reply
);

  logic [15:0] buffer_capacity;
  logic [15:0] max_packet_length;
  logic [15:0] full_sum;
  logic [7:0]  proto;
  logic        load;
  ihrc_pkg::status_t check;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity   <= ihrc_pkg::BUFFER_CAPACITY_RESET;
      max_packet_length <= ihrc_pkg::MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      if (cfg_index == ihrc_pkg::CFG_BUFFER_CAPACITY) begin
        buffer_capacity <= cfg_data;
      end else if (cfg_index == ihrc_pkg::CFG_MAX_LENGTH) begin
        max_packet_length <= cfg_data;
      end
    end
  end

  // checks in priority order
  assign full_sum = ihrc_pkg::oc_add(rec.sum, rec.rx_checksum);
  always_comb begin
    if (rec.byte_count > buffer_capacity) begin
      check = ihrc_pkg::STATUS_BUFFER;
    end else if (rec.byte_count < ihrc_pkg::HDR_BYTES) begin
      check = ihrc_pkg::STATUS_SHORT;
    end else if (rec.byte_count > max_packet_length) begin
      check = ihrc_pkg::STATUS_TOO_LONG;
    end else if (((rec.version_ihl & ihrc_pkg::VERSION_MASK) >> 4) !=
                 {4'd0, ihrc_pkg::EXPECTED_VERSION}) begin
      check = ihrc_pkg::STATUS_VERSION;
    end else if ((rec.version_ihl & ihrc_pkg::IHL_MASK) != {4'd0, ihrc_pkg::IHL_WORDS}) begin
      check = ihrc_pkg::STATUS_IHL;
    end else if (rec.total_length != rec.byte_count) begin
      check = ihrc_pkg::STATUS_LENGTH;
    end else if (full_sum != ihrc_pkg::SUM_GOOD) begin
      check = ihrc_pkg::STATUS_CHECKSUM;
    end else begin
      check = ihrc_pkg::STATUS_OK;
    end
  end

  // protocol only counts once the header is complete
  assign proto = (rec.byte_count >= ihrc_pkg::HDR_BYTES) ? rec.protocol : 8'd0;

  // output register takes a new request whenever it is empty or drains
  assign load = rec_valid && (!out_valid || !out_stall);
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      status            <= check;
      protocol_number   <= proto;
      reply_source      <= rec.dest_ip;
      reply_destination <= rec.source_ip;
      reply_checksum    <= ~rec.sum;
      echo_reply        <= (check == ihrc_pkg::STATUS_OK) && (proto == ihrc_pkg::PROTO_ICMP);
    end
  end

endmodule

`default_nettype wire

// File: src/ipv4_header_receive_check_top.sv
// Top level of the ipv4 header receive check: packet bytes come in on the
// input channel (in_valid/in_stall, data_byte, last_byte), one request per
// byte. On the byte marked last_byte one result request goes out on the
// output channel (out_valid/out_stall) with status, protocol, swapped
// addresses, reply checksum and the echo-reply flag.
// Throughput is one byte per cycle while in_stall is low; a packet's record passes
// through the record queue, then the back check register, and waits on out_stall.
// A two-entry record queue sits between the byte front end and the check
// stage, so bytes keep flowing while a result waits; in_stall rises only
// when that queue is full, which needs a stalled receiver and short packets.
// Reset (rst, synchronous) clears the per-packet state and the queue and
// restores buffer_capacity 2048 and max_packet_length 1500.
// cfg_write with cfg_index 0 or 1 sets buffer_capacity or max_packet_length.
// depends on ihrc_pkg, ihrc_front, ihrc_queue, ihrc_back and the macro header
`default_nettype none

`include "ipv4_header_receive_check_top_macros.svh"

module ipv4_header_receive_check_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [7:0]       protocol_number,
  output logic [31:0]      reply_source,
  output logic [31:0]      reply_destination,
  output logic [15:0]      reply_checksum,
  output logic             echo_reply
);

  logic               accept;
  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  ihrc_pkg::pkt_rec_t push_rec;
  ihrc_pkg::pkt_rec_t head;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // byte front end
  ihrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .rec       (push_rec)
  );

  // record queue
  ihrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .not_empty (q_valid),
    .pop       (pop),
    .head      (head)
  );

  // checks and result register
  ihrc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .rec_valid         (q_valid),
    .rec               (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .protocol_number   (protocol_number),
    .reply_source      (reply_source),
    .reply_destination (reply_destination),
    .reply_checksum    (reply_checksum),
    .echo_reply        (echo_reply)
  );

  // checks
  `IHRC_ASSERT_IMP(a_no_push_when_full, clk, rst, push, !q_full)
  `IHRC_ASSERT_IMP(a_echo_only_when_ok, clk, rst, out_valid && echo_reply,
                   status == ihrc_pkg::STATUS_OK && protocol_number == ihrc_pkg::PROTO_ICMP)
  `IHRC_ASSERT_IMP(a_short_has_no_protocol, clk, rst,
                   out_valid && status == ihrc_pkg::STATUS_SHORT, protocol_number == 8'd0)
  `IHRC_ASSERT_NEXT(a_pop_fills_output, clk, rst, pop, out_valid)

endmodule

`default_nettype wire
